>>> src/rhh_pkg.sv
`timescale 1ns / 1ps
package rhh_pkg;
    localparam int TableSizeDefault  = 64;
    localparam int NameWidthDefault  = 64;
    localparam int ValueWidthDefault = 64;

    localparam int OpcodeWidth = 2;
    localparam int HomeWidth   = 6;
    localparam int KeyWidth    = 64;
    localparam int DataWidth   = 64;
    localparam int StatusWidth = 2;
    localparam int CountWidth  = 7;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_LOOKUP = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    localparam logic [1:0] TAG_EMPTY = 2'd0;
    localparam logic [1:0] TAG_LIVE  = 2'd1;
    localparam logic [1:0] TAG_TOMB  = 2'd2;

    typedef struct packed {
        logic [OpcodeWidth-1:0] opcode;
        logic [HomeWidth-1:0]   home_bucket;
        logic [KeyWidth-1:0]    name_key;
        logic [DataWidth-1:0]   entry_value;
    } t_req;

    typedef struct packed {
        logic [StatusWidth-1:0] status;
        logic [DataWidth-1:0]   found_value;
        logic [CountWidth-1:0]  entry_count;
    } t_rsp;
endpackage

>>> src/rhh_if.sv
`timescale 1ns / 1ps
interface rhh_req_if;
    import rhh_pkg::*;
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rhh_rsp_if;
    import rhh_pkg::*;
    logic valid;
    logic ready;
    t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> src/rhh_store.sv
`timescale 1ns / 1ps
// Slot memories. Each tag entry carries a valid bit, and reset or clear drops
// all of these bits at once. Home, name and value are plain memories.
module rhh_store #(
    parameter int TABLE_SIZE  = rhh_pkg::TableSizeDefault,
    parameter int NAME_WIDTH  = rhh_pkg::NameWidthDefault,
    parameter int VALUE_WIDTH = rhh_pkg::ValueWidthDefault,
    localparam int AW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [AW-1:0]          i_rd_addr,
    output logic [1:0]             o_rd_tag,
    output logic [AW-1:0]          o_rd_home,
    output logic [NAME_WIDTH-1:0]  o_rd_name,
    output logic [VALUE_WIDTH-1:0] o_rd_value,
    input  logic                   i_wr_en,
    input  logic                   i_wr_data_en,
    input  logic [AW-1:0]          i_wr_addr,
    input  logic [1:0]             i_wr_tag,
    input  logic [AW-1:0]          i_wr_home,
    input  logic [NAME_WIDTH-1:0]  i_wr_name,
    input  logic [VALUE_WIDTH-1:0] i_wr_value,
    input  logic                   i_clear
);
    import rhh_pkg::*;

    // A tag whose valid bit is low reads as empty, whatever the tag memory
    // still holds from before the last reset or clear.
    logic [1:0]             m_tag  [TABLE_SIZE];
    logic [TABLE_SIZE-1:0]  r_vld;
    logic [AW-1:0]          m_home [TABLE_SIZE];
    logic [NAME_WIDTH-1:0]  m_name [TABLE_SIZE];
    logic [VALUE_WIDTH-1:0] m_val  [TABLE_SIZE];
    logic [1:0]             r_tag_q;
    logic                   r_vld_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_vld <= '0;
        end else if (i_wr_en) begin
            r_vld[i_wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            m_tag[i_wr_addr] <= i_wr_tag;
        end
        if (i_wr_en && i_wr_data_en) begin
            m_home[i_wr_addr] <= i_wr_home;
            m_name[i_wr_addr] <= i_wr_name;
            m_val[i_wr_addr]  <= i_wr_value;
        end
        r_tag_q    <= m_tag[i_rd_addr];
        r_vld_q    <= r_vld[i_rd_addr];
        o_rd_home  <= m_home[i_rd_addr];
        o_rd_name  <= m_name[i_rd_addr];
        o_rd_value <= m_val[i_rd_addr];
    end

    assign o_rd_tag = r_vld_q ? r_tag_q : TAG_EMPTY;
endmodule

>>> src/robin_hood_hash_table.sv
`timescale 1ns / 1ps
// Robin Hood open-addressing hash table.
// Request channel (i_req, sink): opcode, home_bucket, name_key, entry_value.
// Opcodes are insert, lookup, delete and clear. Response channel (o_rsp,
// source): status, found_value and entry_count, one response per request.
// The block handles one transaction at a time. Each probe step reads one
// slot from the registered slot memory (S_READ) and then evaluates it and
// writes it back if needed (S_EVAL). Lookup and delete probe at most the
// largest displacement seen plus one slot, insert until it finds a free slot.
// A clear drops every tag valid bit at once.
// The response sits in an output register; a new request is taken as soon
// as the result has been loaded into it, even while the receiver stalls,
// and the engine waits only if a second result would overwrite it.
// Reset empties every slot, zeroes the live count and the maximum
// displacement, and empties the response register.
module robin_hood_hash_table #(
    parameter int TABLE_SIZE  = rhh_pkg::TableSizeDefault,
    parameter int NAME_WIDTH  = rhh_pkg::NameWidthDefault,
    parameter int VALUE_WIDTH = rhh_pkg::ValueWidthDefault
) (
    input  logic i_clk,
    input  logic i_rst_n,
    rhh_req_if.sink   i_req,
    rhh_rsp_if.source o_rsp
);
    import rhh_pkg::*;

    localparam int AW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam int CW = $clog2(TABLE_SIZE + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_EVAL = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]             r_state, n_state;
    logic [1:0]             r_op;
    logic [AW-1:0]          r_pos, n_pos;
    logic [AW-1:0]          r_dist, n_dist;
    logic [AW:0]            r_steps, n_steps;
    logic [AW-1:0]          r_home, n_home;
    logic [NAME_WIDTH-1:0]  r_name, n_name;
    logic [VALUE_WIDTH-1:0] r_value, n_value;
    logic [CW-1:0]          r_live, n_live;
    logic [AW-1:0]          r_maxd, n_maxd;
    logic [1:0]             r_status, n_status;
    logic [VALUE_WIDTH-1:0] r_found, n_found;
    logic                   r_ovld;
    t_rsp                   r_out;

    logic [1:0]             rd_tag;
    logic [AW-1:0]          rd_home;
    logic [NAME_WIDTH-1:0]  rd_name;
    logic [VALUE_WIDTH-1:0] rd_value;
    logic                   wr_en, wr_data_en, clr;
    logic [1:0]             wr_tag;
    logic [AW-1:0]          rdist;

    // The home bucket folded into the table size. The remainders are worked
    // out for every bucket code when the design is built, so this is a small
    // constant table rather than a divider.
    function automatic logic [AW-1:0] wrap_home(input logic [HomeWidth-1:0] h);
        logic [AW-1:0] w;
        w = '0;
        for (int k = 0; k < (1 << HomeWidth); k++) begin
            if (h == HomeWidth'(k)) w = AW'(k % TABLE_SIZE);
        end
        return w;
    endfunction

    rhh_store #(
        .TABLE_SIZE(TABLE_SIZE), .NAME_WIDTH(NAME_WIDTH), .VALUE_WIDTH(VALUE_WIDTH)
    ) u_store (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_rd_addr(r_pos), .o_rd_tag(rd_tag), .o_rd_home(rd_home),
        .o_rd_name(rd_name), .o_rd_value(rd_value),
        .i_wr_en(wr_en), .i_wr_data_en(wr_data_en), .i_wr_addr(r_pos),
        .i_wr_tag(wr_tag), .i_wr_home(r_home), .i_wr_name(r_name),
        .i_wr_value(r_value), .i_clear(clr)
    );

    // Distance from the resident's home bucket: the plain difference, with the
    // table size added back when it goes negative.
    always_comb begin
        if (r_pos >= rd_home) begin
            rdist = r_pos - rd_home;
        end else begin
            rdist = AW'((AW+1)'(r_pos) + (AW+1)'(TABLE_SIZE) - (AW+1)'(rd_home));
        end
    end

    assign i_req.ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state; n_pos = r_pos; n_dist = r_dist; n_steps = r_steps;
        n_home = r_home; n_name = r_name; n_value = r_value;
        n_live = r_live; n_maxd = r_maxd; n_status = r_status; n_found = r_found;
        wr_en = 1'b0; wr_data_en = 1'b0; wr_tag = TAG_LIVE; clr = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_pos   = wrap_home(i_req.data.home_bucket);
                    n_home  = wrap_home(i_req.data.home_bucket);
                    n_name  = i_req.data.name_key[NAME_WIDTH-1:0];
                    n_value = i_req.data.entry_value[VALUE_WIDTH-1:0];
                    n_dist  = '0; n_steps = '0;
                    n_status = ST_OK; n_found = '0;
                    if (i_req.data.opcode == OP_CLEAR) begin
                        n_state = S_DONE;
                    end else if (i_req.data.opcode == OP_INSERT &&
                                 r_live == CW'(TABLE_SIZE)) begin
                        n_status = ST_FULL; n_state = S_DONE;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            S_READ: n_state = S_EVAL;
            S_EVAL: begin
                n_state = S_READ;
                n_pos = (r_pos == AW'(TABLE_SIZE - 1)) ? '0 : r_pos + 1'b1;
                n_dist = (r_dist == AW'(TABLE_SIZE - 1)) ? '0 : r_dist + 1'b1;
                n_steps = r_steps + 1'b1;
                if (r_op == OP_INSERT) begin
                    if (rd_tag != TAG_LIVE) begin
                        wr_en = 1'b1; wr_data_en = 1'b1;
                        if (r_dist > r_maxd) n_maxd = r_dist;
                        n_live = r_live + 1'b1; n_state = S_DONE;
                    end else if (r_dist > rdist) begin
                        wr_en = 1'b1; wr_data_en = 1'b1;
                        if (r_dist > r_maxd) n_maxd = r_dist;
                        n_home = rd_home; n_name = rd_name; n_value = rd_value;
                        n_dist = (rdist == AW'(TABLE_SIZE - 1)) ? '0 : rdist + 1'b1;
                    end
                    if (rd_tag == TAG_LIVE && r_steps == (AW+1)'(TABLE_SIZE - 1)) begin
                        n_status = ST_FULL; n_state = S_DONE;
                    end
                end else begin
                    if (rd_tag == TAG_EMPTY) begin
                        n_status = ST_NOTFOUND; n_state = S_DONE;
                    end else if (rd_tag == TAG_LIVE && rd_name == r_name) begin
                        n_state = S_DONE;
                        if (r_op == OP_LOOKUP) begin
                            n_found = rd_value;
                        end else begin
                            wr_en = 1'b1; wr_tag = TAG_TOMB;
                            if (r_live != '0) n_live = r_live - 1'b1;
                        end
                    end else if (r_steps >= (AW+1)'(r_maxd) ||
                                 r_steps == (AW+1)'(TABLE_SIZE - 1)) begin
                        n_status = ST_NOTFOUND; n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (!r_ovld || o_rsp.ready) begin
                    n_state = S_IDLE;
                    if (r_op == OP_CLEAR) begin
                        clr = 1'b1; n_live = '0;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_live <= '0; r_maxd <= '0; r_ovld <= 1'b0;
        end else begin
            r_state <= n_state; r_live <= n_live; r_maxd <= n_maxd;
            if (r_state == S_DONE && (!r_ovld || o_rsp.ready)) begin
                r_ovld <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ovld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_req.valid) r_op <= i_req.data.opcode;
        r_pos <= n_pos; r_dist <= n_dist; r_steps <= n_steps;
        r_home <= n_home; r_name <= n_name; r_value <= n_value;
        r_status <= n_status; r_found <= n_found;
        if (r_state == S_DONE && (!r_ovld || o_rsp.ready)) begin
            r_out.status      <= r_status;
            r_out.found_value <= DataWidth'(r_found);
            r_out.entry_count <= CountWidth'(n_live);
        end
    end

    assign o_rsp.valid = r_ovld;
    assign o_rsp.data  = r_out;
endmodule

>>> src/rhh_checker.sv
`timescale 1ns / 1ps
module rhh_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         req_valid,
    input logic         req_ready,
    input rhh_pkg::t_req req_data,
    input logic         rsp_valid,
    input logic         rsp_ready,
    input rhh_pkg::t_rsp rsp_data
);
    import rhh_pkg::*;

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("response changed while stalled");

    a_no_status3: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid |-> rsp_data.status != 2'd3)
        else $error("undefined status");

    a_clear_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_valid && req_ready && req_data.opcode == OP_CLEAR ##2
        rsp_valid && $rose(rsp_valid) |-> rsp_data.entry_count == '0)
        else $error("clear left entries");

    a_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid && rsp_data.status != ST_OK |-> rsp_data.found_value == '0)
        else $error("value on failure");
endmodule

bind robin_hood_hash_table rhh_checker u_rhh_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .req_valid(i_req.valid), .req_ready(i_req.ready), .req_data(i_req.data),
    .rsp_valid(o_rsp.valid), .rsp_ready(o_rsp.ready), .rsp_data(o_rsp.data)
);

>>> bench/tb.sv
`timescale 1ns / 1ps
module tb;
    import rhh_pkg::*;

    localparam int NSLOT = 64;
    localparam int WATCHDOG_LIMIT = 20000;

    logic i_clk;
    logic i_rst_n;

    rhh_req_if req_ch ();
    rhh_rsp_if rsp_ch ();

    robin_hood_hash_table dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch.sink),
        .o_rsp  (rsp_ch.source)
    );

    // Shadow copy of the table, updated when a request is accepted.
    logic [1:0]  tbl_tag   [NSLOT];
    logic [5:0]  tbl_home  [NSLOT];
    logic [63:0] tbl_name  [NSLOT];
    logic [63:0] tbl_value [NSLOT];
    int          tbl_live;
    int          tbl_maxdist;

    t_req pending_ops [$];
    t_rsp expected_rsp [$];
    logic [63:0] used_names [$];

    int mismatches;
    int n_sent;
    int n_checked;
    int idle_cycles;
    bit stim_done = 1'b0;
    logic req_acc = 1'b0;
    int rsp_gap = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic int probe_find(logic [5:0] home, logic [63:0] name);
        int pos;
        for (int d = 0; d <= tbl_maxdist && d < NSLOT; d++) begin
            pos = (home + d) % NSLOT;
            if (tbl_tag[pos] == TAG_EMPTY) return -1;
            if (tbl_tag[pos] == TAG_LIVE && tbl_name[pos] == name) return pos;
        end
        return -1;
    endfunction

    // Insert with Robin Hood displacement: the carried entry swaps with any
    // resident that lies closer to its own home.
    function automatic logic [1:0] table_insert(logic [5:0] home, logic [63:0] name,
                                                logic [63:0] value);
        int probe_dist;
        int pos;
        int rd;
        logic [5:0]  th;
        logic [63:0] tn;
        logic [63:0] tv;
        probe_dist = 0;
        pos = home;
        if (tbl_live >= NSLOT) return ST_FULL;
        for (int s = 0; s < NSLOT; s++) begin
            if (tbl_tag[pos] != TAG_LIVE) begin
                tbl_tag[pos] = TAG_LIVE;
                tbl_home[pos] = home;
                tbl_name[pos] = name;
                tbl_value[pos] = value;
                if (probe_dist > tbl_maxdist) tbl_maxdist = probe_dist;
                tbl_live++;
                return ST_OK;
            end
            rd = (pos + NSLOT - tbl_home[pos]) % NSLOT;
            if (probe_dist > rd) begin
                th = tbl_home[pos];
                tn = tbl_name[pos];
                tv = tbl_value[pos];
                tbl_home[pos] = home;
                tbl_name[pos] = name;
                tbl_value[pos] = value;
                if (probe_dist > tbl_maxdist) tbl_maxdist = probe_dist;
                home = th;
                name = tn;
                value = tv;
                probe_dist = rd;
            end
            pos = (pos + 1) % NSLOT;
            probe_dist = (probe_dist + 1) % NSLOT;
        end
        return ST_FULL;
    endfunction

    function automatic t_rsp apply_op(t_req op);
        t_rsp r;
        int hit;
        r.status = ST_OK;
        r.found_value = '0;
        case (op.opcode)
            OP_INSERT: begin
                r.status = table_insert(op.home_bucket, op.name_key, op.entry_value);
            end
            OP_LOOKUP: begin
                hit = probe_find(op.home_bucket, op.name_key);
                if (hit < 0) r.status = ST_NOTFOUND;
                else r.found_value = tbl_value[hit];
            end
            OP_DELETE: begin
                hit = probe_find(op.home_bucket, op.name_key);
                if (hit < 0) begin
                    r.status = ST_NOTFOUND;
                end else begin
                    tbl_tag[hit] = TAG_TOMB;
                    if (tbl_live > 0) tbl_live--;
                end
            end
            default: begin
                for (int i = 0; i < NSLOT; i++) tbl_tag[i] = TAG_EMPTY;
                tbl_live = 0;
            end
        endcase
        r.entry_count = tbl_live[6:0];
        return r;
    endfunction

    function automatic t_req make_op(logic [1:0] opc, logic [5:0] home,
                                     logic [63:0] name, logic [63:0] value);
        t_req q;
        q.opcode = opc;
        q.home_bucket = home;
        q.name_key = name;
        q.entry_value = value;
        return q;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Names are mostly drawn from a small pool so that lookups and deletes hit.
    function automatic logic [63:0] pick_name();
        if (used_names.size() > 0 && $urandom_range(0, 3) != 0)
            return used_names[$urandom_range(0, used_names.size() - 1)];
        return rand64();
    endfunction

    // Stimulus. Homes come from a narrow band in some phases so that long
    // displacement chains and wrap-around past slot 63 occur.
    initial begin
        logic [63:0] nm;
        logic [1:0]  opc;
        int band_lo;
        int band_w;
        // Directed part: extremes, duplicates, tombstones, full table, clear.
        pending_ops.push_back(make_op(OP_LOOKUP, 6'd0, 64'd0, 64'd0));
        pending_ops.push_back(make_op(OP_DELETE, 6'd63, '1, '1));
        pending_ops.push_back(make_op(OP_INSERT, 6'd63, '1, '1));
        pending_ops.push_back(make_op(OP_INSERT, 6'd63, 64'd0, 64'd0));
        pending_ops.push_back(make_op(OP_INSERT, 6'd62, 64'h5555_5555_5555_5555,
                                      64'hAAAA_AAAA_AAAA_AAAA));
        pending_ops.push_back(make_op(OP_INSERT, 6'd63, '1, 64'h1234));
        pending_ops.push_back(make_op(OP_LOOKUP, 6'd63, '1, 64'd0));
        pending_ops.push_back(make_op(OP_LOOKUP, 6'd63, 64'd0, 64'd0));
        pending_ops.push_back(make_op(OP_DELETE, 6'd63, '1, 64'd0));
        pending_ops.push_back(make_op(OP_LOOKUP, 6'd63, '1, 64'd0));
        pending_ops.push_back(make_op(OP_INSERT, 6'd0, 64'hAAAA_AAAA_AAAA_AAAA,
                                      64'h5555_5555_5555_5555));
        pending_ops.push_back(make_op(OP_LOOKUP, 6'd62, 64'h5555_5555_5555_5555, 64'd0));
        pending_ops.push_back(make_op(OP_CLEAR, 6'd17, 64'd3, 64'd9));
        pending_ops.push_back(make_op(OP_LOOKUP, 6'd63, 64'd0, 64'd0));
        // Fill the table from one home, then overflow it.
        for (int i = 0; i < NSLOT + 2; i++)
            pending_ops.push_back(make_op(OP_INSERT, 6'd5, 64'(i), rand64()));
        pending_ops.push_back(make_op(OP_LOOKUP, 6'd5, 64'd63, 64'd0));
        pending_ops.push_back(make_op(OP_DELETE, 6'd5, 64'd10, 64'd0));
        pending_ops.push_back(make_op(OP_INSERT, 6'd40, 64'd999, 64'd7));
        pending_ops.push_back(make_op(OP_CLEAR, 6'd0, 64'd0, 64'd0));

        // Random part in phases, some of them closed by a clear.
        while (pending_ops.size() < 1500) begin
            band_lo = $urandom_range(0, 63);
            band_w = ($urandom_range(0, 2) == 0) ? 64 : $urandom_range(1, 8);
            used_names.delete();
            for (int k = 0; k < $urandom_range(40, 120); k++) begin
                opc = $urandom_range(0, 9) < 4 ? OP_INSERT :
                      ($urandom_range(0, 1) ? OP_LOOKUP : OP_DELETE);
                if ($urandom_range(0, 199) == 0) opc = OP_CLEAR;
                nm = (opc == OP_INSERT && $urandom_range(0, 3) != 0) ? rand64() : pick_name();
                if (opc == OP_INSERT) used_names.push_back(nm);
                pending_ops.push_back(make_op(opc, 6'((band_lo + $urandom_range(0, band_w - 1))
                                              % NSLOT), nm, rand64()));
            end
            if ($urandom_range(0, 1)) pending_ops.push_back(make_op(OP_CLEAR, 6'($urandom()),
                                                             rand64(), rand64()));
        end
        stim_done = 1'b1;
    end

    // Driver: one request presented at a time, with random gaps.
    int send_gap;
    initial begin
        i_rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        rsp_ch.ready = 1'b0;
        send_gap = 0;
        tbl_live = 0;
        tbl_maxdist = 0;
        for (int i = 0; i < NSLOT; i++) tbl_tag[i] = TAG_EMPTY;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
    end

    // Remembers whether the request on the channel was taken at the last edge.
    always @(posedge i_clk) begin
        req_acc <= i_rst_n && req_ch.valid && req_ch.ready;
    end

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (req_ch.valid && !req_acc) begin
                // hold the current transaction
            end else if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                req_ch.valid <= 1'b0;
            end else if (pending_ops.size() > 0) begin
                req_ch.valid <= 1'b1;
                req_ch.data <= pending_ops.pop_front();
                send_gap <= ($urandom_range(0, 3) == 0) ? 0 : gap_len();
            end else begin
                req_ch.valid <= 1'b0;
            end
            if (rsp_gap > 0) begin
                rsp_gap <= rsp_gap - 1;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= 1'b1;
                rsp_gap <= ($urandom_range(0, 2) == 0) ? gap_len() : 0;
            end
        end
    end

    // Monitor: predicts on request acceptance, checks on response acceptance.
    t_rsp exp_r;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (req_ch.valid && req_ch.ready) begin
                expected_rsp.push_back(apply_op(req_ch.data));
                n_sent <= n_sent + 1;
            end
            if (rsp_ch.valid && rsp_ch.ready) begin
                n_checked <= n_checked + 1;
                if (expected_rsp.size() == 0) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10) $display("ERROR: unexpected response %p", rsp_ch.data);
                end else begin
                    exp_r = expected_rsp.pop_front();
                    if (exp_r !== rsp_ch.data) begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display("ERROR: status %0d/%0d value %h/%h count %0d/%0d (exp/act)",
                                     exp_r.status, rsp_ch.data.status, exp_r.found_value,
                                     rsp_ch.data.found_value, exp_r.entry_count,
                                     rsp_ch.data.entry_count);
                    end
                end
            end
        end
    end

    initial begin
        mismatches = 0;
        n_sent = 0;
        n_checked = 0;
        idle_cycles = 0;
        wait (i_rst_n);
        while (!(stim_done && pending_ops.size() == 0 && !req_ch.valid
                 && expected_rsp.size() == 0)) begin
            @(posedge i_clk);
            if (idle_cycles > WATCHDOG_LIMIT) begin
                $display("Timeout: no transaction for %0d cycles", idle_cycles);
                $display("*** FAILED ***");
                $finish;
            end
        end
        repeat (300) @(posedge i_clk);
        $display("Ran %0d table operations (insert, lookup, delete, clear), %0d responses checked,",
                 n_sent, n_checked);
        $display("including full-table, wrap-around, duplicate-name and tombstone cases.");
        if (mismatches == 0 && expected_rsp.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
